### hdl/uvs_pkg.sv
`default_nettype none

package uvs_pkg;

  localparam int GRID_BITS_DEF = 8;
  localparam logic [7:0] STACK_COUNT_RESET = 8'd100;
  localparam logic [7:0] SECTOR_COUNT_RESET = 8'd100;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;
  localparam logic [14:0] Q15_MAX = 15'd32767;

  // Horner steps of the cosine series; the sine series has one step fewer.
  localparam int SC_ITER = 7;
  // Phase register, fold, angle, square, three per series step, sine product, output.
  localparam int SC_LAT = 4 + 3 * SC_ITER + 2;

  typedef enum logic [0:0] {
    CFG_STACK_COUNT  = 1'b0,
    CFG_SECTOR_COUNT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic        point_valid;
    logic        upper_valid;
    logic [15:0] upper_a;
    logic [15:0] upper_b;
    logic [15:0] upper_c;
    logic        lower_valid;
    logic [15:0] lower_a;
    logic [15:0] lower_b;
    logic [15:0] lower_c;
  } side_t;

  function automatic logic [7:0] cos_div(input int n);
    case (n)
      0:       return 8'd182;
      1:       return 8'd132;
      2:       return 8'd90;
      3:       return 8'd56;
      4:       return 8'd30;
      5:       return 8'd12;
      default: return 8'd2;
    endcase
  endfunction

  function automatic logic [31:0] cos_recip(input int n);
    case (n)
      0:       return 32'd23598721;
      1:       return 32'd32537631;
      2:       return 32'd47721858;
      3:       return 32'd76695844;
      4:       return 32'd143165576;
      5:       return 32'd357913941;
      default: return 32'd2147483648;
    endcase
  endfunction

  function automatic logic [7:0] sin_div(input int n);
    case (n)
      0:       return 8'd156;
      1:       return 8'd110;
      2:       return 8'd72;
      3:       return 8'd42;
      4:       return 8'd20;
      default: return 8'd6;
    endcase
  endfunction

  function automatic logic [31:0] sin_recip(input int n);
    case (n)
      0:       return 32'd27531841;
      1:       return 32'd39045157;
      2:       return 32'd59652323;
      3:       return 32'd102261126;
      4:       return 32'd214748364;
      default: return 32'd715827882;
    endcase
  endfunction

endpackage

`default_nettype wire

### hdl/uvs_in_if.sv
`default_nettype none

interface uvs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stack_index;
  logic [7:0] sector_index;

  modport source (output valid, output stack_index, output sector_index, input ready);
  modport sink (input valid, input stack_index, input sector_index, output ready);
endinterface

`default_nettype wire

### hdl/uvs_out_if.sv
`default_nettype none

interface uvs_out_if;
  logic               valid;
  logic               ready;
  logic               point_valid;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic               upper_tri_valid;
  logic [15:0]        upper_a;
  logic [15:0]        upper_b;
  logic [15:0]        upper_c;
  logic               lower_tri_valid;
  logic [15:0]        lower_a;
  logic [15:0]        lower_b;
  logic [15:0]        lower_c;

  modport source (
    output valid, output point_valid, output pos_x, output pos_y, output pos_z,
    output upper_tri_valid, output upper_a, output upper_b, output upper_c,
    output lower_tri_valid, output lower_a, output lower_b, output lower_c,
    input ready
  );
  modport sink (
    input valid, input point_valid, input pos_x, input pos_y, input pos_z,
    input upper_tri_valid, input upper_a, input upper_b, input upper_c,
    input lower_tri_valid, input lower_a, input lower_b, input lower_c,
    output ready
  );
endinterface

`default_nettype wire

### hdl/uvs_div.sv
`default_nettype none

module uvs_div
  import uvs_pkg::*;
#(
  parameter int GRID_BITS = GRID_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [GRID_BITS+31:0]   dividend,
  input  wire logic [GRID_BITS-1:0]    divisor,
  output logic      [31:0]             quotient
);

  localparam int DW = GRID_BITS + 32;

  logic [GRID_BITS-1:0] rem [1:DW];
  logic [DW-1:0]        dvd [1:DW];
  logic [31:0]          quo [1:DW];

  for (genvar s = 0; s < DW; s++) begin : g_step
    logic [GRID_BITS-1:0] rin;
    logic [DW-1:0]        din;
    logic [31:0]          qin;
    logic [GRID_BITS:0]   trial;
    logic [GRID_BITS:0]   diff;
    logic                 ge;

    if (s == 0) begin : g_first
      assign rin = '0;
      assign din = dividend;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem[s];
      assign din = dvd[s];
      assign qin = quo[s];
    end

    assign trial = {rin, din[DW-1]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = trial >= {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? diff[GRID_BITS-1:0] : trial[GRID_BITS-1:0];
        dvd[s+1] <= din << 1;
        quo[s+1] <= {qin[30:0], ge};
      end
    end
  end

  assign quotient = quo[DW];

endmodule

`default_nettype wire

### hdl/uvs_sincos.sv
`default_nettype none

module uvs_sincos
  import uvs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [31:0]        phase,
  output logic signed [15:0]      sin_q15,
  output logic signed [15:0]      cos_q15
);

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic [1:0]  quad;
    logic        swap;
  } ctx_t;

  function automatic logic [14:0] to_q15(input logic [30:0] v);
    logic [31:0] t;
    t = {1'b0, v} + 32'h0000_4000;
    if (t[31:15] > {2'b0, Q15_MAX}) return Q15_MAX;
    return t[29:15];
  endfunction

  logic [31:0] ph;
  logic [1:0]  f_quad;
  logic        f_swap;
  logic [29:0] f_r;
  logic [30:0] f_unfold;
  logic [60:0] x_prod;
  logic [29:0] a_x;
  logic [1:0]  a_quad;
  logic        a_swap;
  logic [59:0] x2_prod;

  ctx_t        ctx    [0:SC_ITER];
  logic [30:0] tc_q   [0:SC_ITER];
  logic [30:0] ts_q   [0:SC_ITER];

  assign f_unfold = Q30_ONE - {1'b0, ph[29:0]};
  assign x_prod   = f_r * PI_HALF_Q30;
  assign x2_prod  = a_x * a_x;

  always_ff @(posedge clk) begin
    if (en) begin
      ph     <= phase;
      f_quad <= ph[31:30];
      if (ph[29:0] > 30'h2000_0000) begin
        f_r    <= f_unfold[29:0];
        f_swap <= 1'b1;
      end else begin
        f_r    <= ph[29:0];
        f_swap <= 1'b0;
      end
      a_x    <= x_prod[59:30];
      a_quad <= f_quad;
      a_swap <= f_swap;
      ctx[0] <= '{x: a_x, x2: x2_prod[59:30], quad: a_quad, swap: a_swap};
    end
  end

  assign tc_q[0] = Q30_ONE;
  assign ts_q[0] = Q30_ONE;

  for (genvar n = 0; n < SC_ITER; n++) begin : g_iter
    localparam logic [7:0]  DC = cos_div(n);
    localparam logic [31:0] MC = cos_recip(n);
    localparam logic [7:0]  DS = sin_div(n);
    localparam logic [31:0] MS = sin_recip(n);

    ctx_t        ctx_a, ctx_b;
    logic [29:0] vc_a, vs_a, vc_b, vs_b;
    logic [30:0] ts_a, ts_b;
    logic [29:0] q0c_b, q0s_b;
    logic [60:0] pc, ps;
    logic [61:0] mc, ms;
    logic [37:0] dc_prod, ds_prod;
    logic [31:0] rc, rs;
    logic [30:0] qc, qs;

    assign pc      = ctx[n].x2 * tc_q[n];
    assign ps      = ctx[n].x2 * ts_q[n];
    assign mc      = vc_a * MC;
    assign ms      = vs_a * MS;
    assign dc_prod = q0c_b * DC;
    assign ds_prod = q0s_b * DS;
    assign rc      = {2'b0, vc_b} - dc_prod[31:0];
    assign rs      = {2'b0, vs_b} - ds_prod[31:0];
    assign qc      = {1'b0, q0c_b} + 31'(rc >= 32'(DC));
    assign qs      = {1'b0, q0s_b} + 31'(rs >= 32'(DS));

    always_ff @(posedge clk) begin
      if (en) begin
        ctx_a <= ctx[n];
        vc_a  <= pc[59:30];
        vs_a  <= ps[59:30];
        ts_a  <= ts_q[n];
        ctx_b <= ctx_a;
        vc_b  <= vc_a;
        vs_b  <= vs_a;
        ts_b  <= ts_a;
        q0c_b <= mc[61:32];
        q0s_b <= ms[61:32];
        ctx[n+1]  <= ctx_b;
        tc_q[n+1] <= Q30_ONE - qc;
        if (n < SC_ITER - 1) begin
          ts_q[n+1] <= Q30_ONE - qs;
        end else begin
          ts_q[n+1] <= ts_b;
        end
      end
    end
  end

  logic [60:0] sv_prod;
  logic [30:0] e_sv;
  logic [30:0] e_cv;
  logic [1:0]  e_quad;
  logic        e_swap;
  logic [14:0] s_m;
  logic [14:0] c_m;
  logic signed [15:0] s_p, c_p;

  assign sv_prod = ctx[SC_ITER].x * ts_q[SC_ITER];
  assign s_m = e_swap ? to_q15(e_cv) : to_q15(e_sv);
  assign c_m = e_swap ? to_q15(e_sv) : to_q15(e_cv);
  assign s_p = $signed({1'b0, s_m});
  assign c_p = $signed({1'b0, c_m});

  always_ff @(posedge clk) begin
    if (en) begin
      e_sv   <= sv_prod[60:30];
      e_cv   <= tc_q[SC_ITER];
      e_quad <= ctx[SC_ITER].quad;
      e_swap <= ctx[SC_ITER].swap;
      case (e_quad)
        2'd0: begin
          sin_q15 <= s_p;
          cos_q15 <= c_p;
        end
        2'd1: begin
          sin_q15 <= c_p;
          cos_q15 <= -s_p;
        end
        2'd2: begin
          sin_q15 <= -s_p;
          cos_q15 <= -c_p;
        end
        default: begin
          sin_q15 <= -c_p;
          cos_q15 <= s_p;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/uv_sphere_vertex_and_index_gen.sv
`default_nettype none

// UV-sphere generator: each item is a grid point (stack row, sector column) and
// yields one result with the unit-sphere vertex in Q1.15 (also the normal) and
// the two triangles of the grid cell as vertex indices. One item is accepted
// every clock cycle while the result side does not stall. The bit-per-stage
// dividers that form the angle phases are followed by the staged sine and
// cosine series. A stall on the result side holds the whole pipeline. The
// counts are taken live, so the user must change them only while no item is
// in flight; the block itself does not enforce this.
module uv_sphere_vertex_and_index_gen
  import uvs_pkg::*;
#(
  parameter int GRID_BITS = GRID_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  uvs_in_if.sink          point,
  uvs_out_if.source       result
);

  localparam int G  = GRID_BITS;
  localparam int DW = G + 32;
  localparam int L  = DW + SC_LAT + 1;

  function automatic logic signed [15:0] mul_q15(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic [15:0] ma, mb;
    logic [31:0] m;
    logic [15:0] r;
    ma = a[15] ? 16'(-a) : 16'(a);
    mb = b[15] ? 16'(-b) : 16'(b);
    m  = ma * mb + 32'h0000_4000;
    r  = (m[31:15] > 17'd32767) ? 16'd32767 : m[30:15];
    return (a[15] != b[15]) ? -$signed(r) : $signed(r);
  endfunction

  logic [7:0] stack_count;
  logic [7:0] sector_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count  <= STACK_COUNT_RESET;
      sector_count <= SECTOR_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STACK_COUNT:  stack_count  <= cfg_data;
        CFG_SECTOR_COUNT: sector_count <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [G-1:0] st_m, se_m, st, se, i, j;
  logic [G:0]   se_p1;
  logic         grid_cell;
  logic [2*G:0] k1w;
  logic [15:0]  k1, k2;
  side_t        side_in;

  assign st_m  = G'(stack_count);
  assign se_m  = G'(sector_count);
  assign st    = (st_m < G'(2)) ? G'(2) : st_m;
  assign se    = (se_m < G'(3)) ? G'(3) : se_m;
  assign i     = G'(point.stack_index);
  assign j     = G'(point.sector_index);
  assign se_p1 = {1'b0, se} + (G+1)'(1);
  assign k1w   = {{(G+1){1'b0}}, i} * {{G{1'b0}}, se_p1} + {{(G+1){1'b0}}, j};
  assign k1    = 16'(k1w);
  assign k2    = k1 + 16'(se_p1);
  assign grid_cell = (i < st) && (j < se);

  always_comb begin
    side_in = '0;
    side_in.point_valid = (i <= st) && (j <= se);
    if (grid_cell && (i != '0)) begin
      side_in.upper_valid = 1'b1;
      side_in.upper_a     = k1;
      side_in.upper_b     = k2;
      side_in.upper_c     = k1 + 16'd1;
    end
    if (grid_cell && (i != st - G'(1))) begin
      side_in.lower_valid = 1'b1;
      side_in.lower_a     = k1 + 16'd1;
      side_in.lower_b     = k2;
      side_in.lower_c     = k2 + 16'd1;
    end
  end

  logic          en;
  logic          vld [1:L];
  side_t         sb  [1:L];

  assign en = !vld[L] || result.ready;
  assign point.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= L; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[1] <= point.valid;
      for (int k = 2; k <= L; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb[1] <= side_in;
      for (int k = 2; k <= L; k++) sb[k] <= sb[k-1];
    end
  end

  logic [DW-1:0] dvd_sec, dvd_stk;
  logic [31:0]   sec_ph, stk_off, stk_ph;
  logic signed [15:0] sj, cj, ss, cs;

  assign dvd_sec = {j, 32'(se >> 1)};
  assign dvd_stk = {1'b0, i, 31'(st >> 1)};

  uvs_div #(.GRID_BITS(G)) u_div_sec (
    .clk(clk), .en(en), .dividend(dvd_sec), .divisor(se), .quotient(sec_ph)
  );

  uvs_div #(.GRID_BITS(G)) u_div_stk (
    .clk(clk), .en(en), .dividend(dvd_stk), .divisor(st), .quotient(stk_off)
  );

  assign stk_ph = 32'h4000_0000 - stk_off;

  uvs_sincos u_sc_sec (
    .clk(clk), .en(en), .phase(sec_ph), .sin_q15(sj), .cos_q15(cj)
  );

  uvs_sincos u_sc_stk (
    .clk(clk), .en(en), .phase(stk_ph), .sin_q15(ss), .cos_q15(cs)
  );

  logic signed [15:0] pos_x, pos_y, pos_z;

  always_ff @(posedge clk) begin
    if (en) begin
      if (sb[L-1].point_valid) begin
        pos_x <= mul_q15(cs, cj);
        pos_y <= mul_q15(cs, sj);
        pos_z <= ss;
      end else begin
        pos_x <= '0;
        pos_y <= '0;
        pos_z <= '0;
      end
    end
  end

  assign result.valid           = vld[L];
  assign result.point_valid     = sb[L].point_valid;
  assign result.pos_x           = pos_x;
  assign result.pos_y           = pos_y;
  assign result.pos_z           = pos_z;
  assign result.upper_tri_valid = sb[L].upper_valid;
  assign result.upper_a         = sb[L].upper_a;
  assign result.upper_b         = sb[L].upper_b;
  assign result.upper_c         = sb[L].upper_c;
  assign result.lower_tri_valid = sb[L].lower_valid;
  assign result.lower_a         = sb[L].lower_a;
  assign result.lower_b         = sb[L].lower_b;
  assign result.lower_c         = sb[L].lower_c;

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.point_valid |-> pos_x == '0 && pos_y == '0 && pos_z == '0)
    else $error("position not cleared for a point outside the grid");

  a_upper_step: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.upper_tri_valid |-> result.upper_c == result.upper_a + 16'd1)
    else $error("upper triangle indices inconsistent");

  a_shared_edge: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.upper_tri_valid && result.lower_tri_valid
    |-> result.lower_a == result.upper_c && result.lower_b == result.upper_b)
    else $error("triangles of one cell do not share their edge");

  a_tri_in_grid: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.upper_tri_valid || result.lower_tri_valid)
    |-> result.point_valid)
    else $error("triangle given for a point outside the grid");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !result.valid)
    else $error("result valid straight after reset");

endmodule

`default_nettype wire

### sim/uv_sphere_vertex_and_index_gen_tb.sv
`default_nettype none

module uv_sphere_vertex_and_index_gen_tb;
  import uvs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        point_valid;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic        upper_valid;
    logic [15:0] upper_a;
    logic [15:0] upper_b;
    logic [15:0] upper_c;
    logic        lower_valid;
    logic [15:0] lower_a;
    logic [15:0] lower_b;
    logic [15:0] lower_c;
  } vertex_t;

  class sphere_scoreboard;
    logic [7:0] stacks;
    logic [7:0] sectors;
    vertex_t    vertex_q[$];
    int         mismatches;
    int         unexpected;

    function new();
      stacks = STACK_COUNT_RESET;
      sectors = SECTOR_COUNT_RESET;
      mismatches = 0;
      unexpected = 0;
    endfunction

    function int round_q15(longint unsigned v);
      longint unsigned r;
      r = (v + 64'd16384) >> 15;
      if (r > 64'd32767) r = 64'd32767;
      return int'(r);
    endfunction

    function void sine_cosine(logic [31:0] phase, output int s_out, output int c_out);
      logic [1:0]      quad;
      longint unsigned r, x, x2, ts, tc, sv;
      bit              swap;
      int              s, c;
      quad = phase[31:30];
      r = 64'(phase[29:0]);
      swap = 0;
      if (r > 64'd536870912) begin
        r = 64'd1073741824 - r;
        swap = 1;
      end
      x = (r * 64'd1686629713) >> 30;
      x2 = (x * x) >> 30;
      ts = 64'd1073741824;
      for (int k = 13; k >= 3; k -= 2)
        ts = 64'd1073741824 - ((x2 * ts) >> 30) / longint'(k * (k - 1));
      tc = 64'd1073741824;
      for (int k = 14; k >= 2; k -= 2)
        tc = 64'd1073741824 - ((x2 * tc) >> 30) / longint'(k * (k - 1));
      sv = (x * ts) >> 30;
      if (swap) begin
        s = round_q15(tc);
        c = round_q15(sv);
      end else begin
        s = round_q15(sv);
        c = round_q15(tc);
      end
      case (quad)
        2'd0: begin s_out = s; c_out = c; end
        2'd1: begin s_out = c; c_out = -s; end
        2'd2: begin s_out = -s; c_out = -c; end
        default: begin s_out = -c; c_out = s; end
      endcase
    endfunction

    function int mul_q15(int a, int b);
      bit          neg;
      int unsigned ma, mb, m;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      m = (ma * mb + 32'd16384) >> 15;
      if (m > 32'd32767) m = 32'd32767;
      return neg ? -int'(m) : int'(m);
    endfunction

    function void note_point(logic [7:0] i, logic [7:0] j);
      vertex_t         v;
      int unsigned     st, se, k1, k2;
      longint unsigned sec_ph, off;
      logic [31:0]     stk_ph;
      int              ss, cs, sj, cj;
      st = 32'(stacks);
      se = 32'(sectors);
      if (st < 2) st = 2;
      if (se < 3) se = 3;
      v = '0;
      if (i <= st && j <= se) begin
        sec_ph = ((longint'(j) << 32) + se / 2) / se;
        off = ((longint'(i) << 31) + st / 2) / st;
        stk_ph = 32'h4000_0000 - off[31:0];
        sine_cosine(stk_ph, ss, cs);
        sine_cosine(sec_ph[31:0], sj, cj);
        v.point_valid = 1'b1;
        v.pos_x = 16'(mul_q15(cs, cj));
        v.pos_y = 16'(mul_q15(cs, sj));
        v.pos_z = 16'(ss);
      end
      if (i < st && j < se) begin
        k1 = i * (se + 1) + j;
        k2 = k1 + se + 1;
        if (i != 0) begin
          v.upper_valid = 1'b1;
          v.upper_a = 16'(k1);
          v.upper_b = 16'(k2);
          v.upper_c = 16'(k1 + 1);
        end
        if (i != st - 1) begin
          v.lower_valid = 1'b1;
          v.lower_a = 16'(k1 + 1);
          v.lower_b = 16'(k2);
          v.lower_c = 16'(k2 + 1);
        end
      end
      vertex_q.insert(vertex_q.size(), v);
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch %s: expected %0h, got %0h", name, want, got);
      end
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t want;
      if (vertex_q.size() == 0) begin
        unexpected++;
        mismatches++;
        if (mismatches <= 10) $display("result with no item outstanding");
        return;
      end
      want = vertex_q.pop_front();
      compare("point_valid", 16'(want.point_valid), 16'(got.point_valid));
      compare("pos_x", want.pos_x, got.pos_x);
      compare("pos_y", want.pos_y, got.pos_y);
      compare("pos_z", want.pos_z, got.pos_z);
      compare("upper_tri_valid", 16'(want.upper_valid), 16'(got.upper_valid));
      compare("upper_a", want.upper_a, got.upper_a);
      compare("upper_b", want.upper_b, got.upper_b);
      compare("upper_c", want.upper_c, got.upper_c);
      compare("lower_tri_valid", 16'(want.lower_valid), 16'(got.lower_valid));
      compare("lower_a", want.lower_a, got.lower_a);
      compare("lower_b", want.lower_b, got.lower_b);
      compare("lower_c", want.lower_c, got.lower_c);
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [0:0] cfg_index;
  logic [7:0] cfg_data;

  uvs_in_if  point();
  uvs_out_if result();

  sphere_scoreboard sb;
  bit send_gaps;
  bit recv_gaps;
  int hold_off;

  uv_sphere_vertex_and_index_gen i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .point     (point.sink),
    .result    (result.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    vertex_t got;
    if (!rst && point.valid && point.ready)
      sb.note_point(point.stack_index, point.sector_index);
    if (!rst && result.valid && result.ready) begin
      got.point_valid = result.point_valid;
      got.pos_x = result.pos_x;
      got.pos_y = result.pos_y;
      got.pos_z = result.pos_z;
      got.upper_valid = result.upper_tri_valid;
      got.upper_a = result.upper_a;
      got.upper_b = result.upper_b;
      got.upper_c = result.upper_c;
      got.lower_valid = result.lower_tri_valid;
      got.lower_a = result.lower_a;
      got.lower_b = result.lower_b;
      got.lower_c = result.lower_c;
      sb.check_vertex(got);
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int n;
    result.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off > 0) begin
        n = hold_off;
        hold_off = 0;
        result.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
        result.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        result.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic write_reg(cfg_index_t idx, logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_STACK_COUNT) sb.stacks = value;
    else sb.sectors = value;
  endtask

  task automatic set_counts(logic [7:0] st, logic [7:0] se);
    write_reg(CFG_STACK_COUNT, st);
    write_reg(CFG_SECTOR_COUNT, se);
  endtask

  task automatic send_point(logic [7:0] i, logic [7:0] j);
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      point.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    point.valid <= 1'b1;
    point.stack_index <= i;
    point.sector_index <= j;
    @(posedge clk);
    while (!point.ready) @(posedge clk);
  endtask

  task automatic send_random(int count);
    int unsigned st, se;
    logic [7:0]  i, j;
    st = (sb.stacks < 8'd2) ? 32'd2 : 32'(sb.stacks);
    se = (sb.sectors < 8'd3) ? 32'd3 : 32'(sb.sectors);
    repeat (count) begin
      if ($urandom_range(0, 9) < 2) begin
        i = 8'($urandom);
        j = 8'($urandom);
      end else begin
        i = 8'($urandom_range(0, (st + 1 > 255) ? 255 : st + 1));
        j = 8'($urandom_range(0, (se + 1 > 255) ? 255 : se + 1));
      end
      send_point(i, j);
    end
  endtask

  task automatic drain();
    point.valid <= 1'b0;
    @(posedge clk);
    while (sb.vertex_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  initial begin
    sb = new();
    send_gaps = 1;
    recv_gaps = 1;
    hold_off = 0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_STACK_COUNT;
    cfg_data <= '0;
    point.valid <= 1'b0;
    point.stack_index <= '0;
    point.sector_index <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_point(0, 0);
    send_point(0, 100);
    send_point(100, 0);
    send_point(100, 100);
    send_point(99, 99);
    send_point(1, 0);
    send_point(99, 0);
    send_point(0, 99);
    send_point(50, 25);
    send_point(50, 50);
    send_point(25, 75);
    send_point(75, 12);
    send_point(101, 0);
    send_point(0, 101);
    send_point(101, 101);
    send_point(128, 128);
    send_point(255, 255);
    send_point(255, 0);
    send_point(0, 255);
    drain();

    set_counts(8'd2, 8'd3);
    send_point(0, 0);
    send_point(1, 3);
    send_point(2, 3);
    send_point(3, 0);
    send_random(200);
    drain();

    set_counts(8'd255, 8'd255);
    send_point(254, 254);
    send_point(255, 255);
    send_point(0, 255);
    send_random(120);
    hold_off = 300;
    send_random(120);
    drain();

    set_counts(8'd0, 8'd1);
    send_random(150);
    drain();

    set_counts(8'd1, 8'd2);
    send_random(100);
    drain();

    repeat (4) begin
      set_counts(8'($urandom_range(2, 255)), 8'($urandom_range(3, 255)));
      send_random(200);
      drain();
    end

    send_gaps = 0;
    recv_gaps = 0;
    set_counts(8'($urandom_range(2, 40)), 8'($urandom_range(3, 40)));
    send_random(200);
    drain();

    repeat (80) @(posedge clk);
    if (sb.mismatches == 0 && sb.vertex_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
hdl/uvs_pkg.sv
hdl/uvs_in_if.sv
hdl/uvs_out_if.sv
hdl/uvs_div.sv
hdl/uvs_sincos.sv
hdl/uv_sphere_vertex_and_index_gen.sv
sim/uv_sphere_vertex_and_index_gen_tb.sv
